@@ hdl/dgl_pkg.sv @@
// Package for the graph labeler: point kind codes, widths, min_points reset and the popcount helper.
// Has no dependencies; the top level uses it by scoped names.
package dgl_pkg;

   localparam int unsigned RowWidth = 64;
   localparam int unsigned IndexWidth = 6;
   localparam int unsigned ClusterWidth = 7;
   localparam int unsigned CountWidth = 7;

   localparam logic [1:0] KIND_CORE   = 2'd0;
   localparam logic [1:0] KIND_BORDER = 2'd1;
   localparam logic [1:0] KIND_NOISE  = 2'd2;

   localparam logic [6:0] MIN_POINTS_RESET = 7'd10;

   // Ones count of one byte; the wide count is built one byte a cycle.
   function automatic logic [3:0] count_byte(input logic [7:0] value);
      logic [3:0] total;
      total = 4'd0;
      for (int k = 0; k < 8; k++) begin
         total = total + {3'd0, value[k]};
      end
      return total;
   endfunction

endpackage

@@ hdl/dgl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dgl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/dbscan_graph_labeler_unit.sv @@
// Top level of the graph labeler: row memory, labeling sequencer and result register.
// Depends on dgl_pkg and dgl_ram.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| point_index, neighbor_bits, last_row
//  rsp     | out       | rsp_valid/rsp_stall| out_index, point_kind, cluster_number, last_result
//  csr     | in        | csr_write          | csr_data (min_points)
//
// Rows are taken whenever the unit is loading. After the last row of N points the
// sequencer walks the row memory through its single read port: a ones count per
// point (read, wait, then byte by byte), a border pass per point (read, wait, evaluate),
// a seed scan over the points, and an expansion that reads each core row once (pick,
// wait, merge, write each point it labels), then N results at one a cycle unless stalled.
// Reset is synchronous and clears control state only; cluster entries of unlabeled
// points are masked at the output, so no clearing pass is needed.
// Requests are stalled throughout labeling; result stalls hold the output register.
module dbscan_graph_labeler_unit #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_point_index,
   input  logic [63:0] req_neighbor_bits,
   input  logic        req_last_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_out_index,
   output logic [1:0]  rsp_point_kind,
   output logic [6:0]  rsp_cluster_number,
   output logic        rsp_last_result,
   input  logic        csr_write,
   input  logic [6:0]  csr_data
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_CRD    = 4'd1;  // count: issue read
   localparam logic [3:0] ST_CWAIT  = 4'd2;
   localparam logic [3:0] ST_CBYTE  = 4'd3;  // count: one byte a cycle
   localparam logic [3:0] ST_BRD    = 4'd4;  // border: issue read
   localparam logic [3:0] ST_BWAIT  = 4'd5;
   localparam logic [3:0] ST_BEVAL  = 4'd6;
   localparam logic [3:0] ST_SCAN   = 4'd7;  // look for next unlabeled core seed
   localparam logic [3:0] ST_FPICK  = 4'd8;  // pick lowest frontier point
   localparam logic [3:0] ST_FWAIT  = 4'd9;
   localparam logic [3:0] ST_FMERGE = 4'd10;
   localparam logic [3:0] ST_EMIT   = 4'd11;
   localparam logic [3:0] ST_FWRITE = 4'd12; // store cluster of newly labeled points

   logic [3:0]  state_ff, state_in;
   logic [6:0]  min_points_ff;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] scan_ff;
   logic [2:0]  byte_ff, byte_in;
   logic [6:0]  count_ff, count_in;
   logic [63:0] live_ff, live_in;
   logic [63:0] core_ff, core_in;
   logic [63:0] noise_ff, noise_in;
   logic [63:0] labeled_ff, labeled_in;
   logic [63:0] frontier_ff, frontier_in;
   logic [63:0] pend_ff, pend_in;
   logic [6:0]  cluster_ff, cluster_in;
   logic [63:0] row_mask;
   logic        rsp_valid_ff;
   logic [5:0]  rsp_index_ff;
   logic [1:0]  rsp_kind_ff;
   logic [6:0]  rsp_cluster_ff;
   logic        rsp_last_ff;

   logic          ram_we;
   logic [AW-1:0] ram_rd_addr;
   logic [63:0]   ram_rd_data;
   logic          cl_we;
   logic [AW-1:0] cl_wr_addr;
   logic [6:0]    cl_wr_data;
   logic [6:0]    cl_rd_data;
   logic          req_take;
   logic          req_in_range;
   logic [63:0]   self_bit;
   logic [63:0]   fresh;
   logic          emit_go;
   logic [63:0]   pick_mask;
   logic [AW-1:0] pick_lowest;
   logic [AW-1:0] ptr_next;

   assign req_in_range = ({26'd0, req_point_index} < 32'(MAX_POINTS));
   assign req_stall = (state_ff != ST_LOAD);
   assign req_take = req_valid && !req_stall;
   assign ram_we = req_take && req_in_range;
   assign ptr_next = ptr_ff + AW'(1);

   dgl_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_rows (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(req_point_index[AW-1:0]),
      .wr_data(req_neighbor_bits),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // The row just read, without its self bit and points past the count.
   assign self_bit = 64'd1 << ptr_ff;
   assign row_mask = ram_rd_data & live_ff & ~self_bit;
   assign fresh = row_mask & ~noise_ff & ~labeled_ff;

   // Lowest set bit of the frontier, or of the points still waiting for their cluster.
   assign pick_mask = (state_ff == ST_FWRITE) ? pend_ff : frontier_ff;
   always_comb begin
      pick_lowest = '0;
      for (int k = MAX_POINTS - 1; k >= 0; k--) begin
         if (pick_mask[k]) begin
            pick_lowest = AW'(k);
         end
      end
   end

   assign ram_rd_addr = (state_ff == ST_FPICK) ? pick_lowest : ptr_ff;
   assign emit_go = !rsp_valid_ff || !rsp_stall;

   // Labeling sequencer.
   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      last_in = last_ff;
      byte_in = byte_ff;
      count_in = count_ff;
      live_in = live_ff;
      core_in = core_ff;
      noise_in = noise_ff;
      labeled_in = labeled_ff;
      frontier_in = frontier_ff;
      pend_in = pend_ff;
      cluster_in = cluster_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && req_in_range && req_last_row) begin
               last_in = req_point_index[AW-1:0];
               live_in = (req_point_index == 6'd63) ? {64{1'b1}}
                         : ((64'd1 << (req_point_index + 6'd1)) - 64'd1);
               ptr_in = '0;
               core_in = '0;
               noise_in = '0;
               labeled_in = '0;
               cluster_in = '0;
               state_in = ST_CRD;
            end
         end
         ST_CRD: state_in = ST_CWAIT;
         ST_CWAIT: begin
            byte_in = '0;
            count_in = '0;
            state_in = ST_CBYTE;
         end
         ST_CBYTE: begin
            count_in = count_ff + {3'd0, dgl_pkg::count_byte(row_mask[byte_ff*8 +: 8])};
            byte_in = byte_ff + 3'd1;
            if (byte_ff == 3'd7) begin
               core_in[ptr_ff] = (count_in >= min_points_ff);
               if (ptr_ff == last_ff) begin
                  ptr_in = '0;
                  state_in = ST_BRD;
               end else begin
                  ptr_in = ptr_next;
                  state_in = ST_CRD;
               end
            end
         end
         ST_BRD: state_in = ST_BWAIT;
         ST_BWAIT: state_in = ST_BEVAL;
         ST_BEVAL: begin
            noise_in[ptr_ff] = !core_ff[ptr_ff] && ((row_mask & core_ff) == 64'd0);
            if (ptr_ff == last_ff) begin
               ptr_in = '0;
               state_in = ST_SCAN;
            end else begin
               ptr_in = ptr_next;
               state_in = ST_BRD;
            end
         end
         ST_SCAN: begin
            if (core_ff[ptr_ff] && !labeled_ff[ptr_ff]) begin
               cluster_in = cluster_ff + 7'd1;
               labeled_in[ptr_ff] = 1'b1;
               frontier_in = self_bit;
               state_in = ST_FPICK;
            end else if (ptr_ff == last_ff) begin
               ptr_in = '0;
               state_in = ST_EMIT;
            end else begin
               ptr_in = ptr_next;
            end
         end
         ST_FPICK: begin
            if (frontier_ff == 64'd0) begin
               ptr_in = scan_ff;
               state_in = ST_SCAN;
            end else begin
               frontier_in[pick_lowest] = 1'b0;
               ptr_in = pick_lowest;
               last_in = last_ff;
               state_in = ST_FWAIT;
            end
         end
         ST_FWAIT: state_in = ST_FMERGE;
         ST_FMERGE: begin
            labeled_in = labeled_ff | fresh;
            frontier_in = frontier_ff | (fresh & core_ff);
            pend_in = fresh;
            state_in = ST_FWRITE;
         end
         ST_FWRITE: begin
            if (pend_ff == 64'd0) begin
               state_in = ST_FPICK;
            end else begin
               pend_in[pick_lowest] = 1'b0;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (ptr_ff == last_ff) begin
                  ptr_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  ptr_in = ptr_next;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // The expansion moves ptr to the frontier rows; remember the scan position.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN) begin
         scan_ff <= ptr_ff;
      end
   end

   // Cluster numbers per point, one write a cycle: the seed in the scan, then each
   // newly labeled point. The read follows the next pointer so data lines up with ptr.
   assign cl_we = (state_ff == ST_SCAN && core_ff[ptr_ff] && !labeled_ff[ptr_ff])
                  || (state_ff == ST_FWRITE && pend_ff != 64'd0);
   assign cl_wr_addr = (state_ff == ST_FWRITE) ? pick_lowest : ptr_ff;
   assign cl_wr_data = (state_ff == ST_FWRITE) ? cluster_ff : cluster_in;

   dgl_ram #(.WIDTH(7), .DEPTH(MAX_POINTS)) u_clusters (
      .clock  (clock),
      .wr_en  (cl_we),
      .wr_addr(cl_wr_addr),
      .wr_data(cl_wr_data),
      .rd_addr(ptr_in),
      .rd_data(cl_rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         min_points_ff <= dgl_pkg::MIN_POINTS_RESET;
         ptr_ff <= '0;
         frontier_ff <= '0;
         labeled_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            min_points_ff <= csr_data;
         end
         ptr_ff <= ptr_in;
         frontier_ff <= frontier_in;
         labeled_ff <= labeled_in;
      end
   end

   // Payload-like working registers.
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      byte_ff <= byte_in;
      count_ff <= count_in;
      live_ff <= live_in;
      core_ff <= core_in;
      noise_ff <= noise_in;
      pend_ff <= pend_in;
      cluster_ff <= cluster_in;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= (state_ff == ST_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_index_ff <= 6'(ptr_ff);
         rsp_kind_ff <= core_ff[ptr_ff] ? dgl_pkg::KIND_CORE
                        : (noise_ff[ptr_ff] ? dgl_pkg::KIND_NOISE : dgl_pkg::KIND_BORDER);
         rsp_cluster_ff <= cl_rd_data & {7{labeled_ff[ptr_ff]}};
         rsp_last_ff <= (ptr_ff == last_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_point_kind = rsp_kind_ff;
   assign rsp_cluster_number = rsp_cluster_ff;
   assign rsp_last_result = rsp_last_ff;

   // Requests are only taken while loading rows.
   assert property (@(posedge clock) disable iff (reset)
      req_take |-> state_ff == ST_LOAD)
      else $error("request taken during labeling");

   // A last row that is in range always starts the ones count.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_in_range && req_last_row) |=> state_ff == ST_CRD)
      else $error("labeling did not start");

   // Every frontier point is a labeled core point.
   assert property (@(posedge clock) disable iff (reset)
      (frontier_ff & ~(core_ff & labeled_ff)) == 64'd0)
      else $error("frontier holds an unlabeled or non-core point");

   // A stalled result holds still.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_out_index))
      else $error("stalled result changed");

endmodule
